FILE: rtl/hsp_pkg.sv
// Shared types and codes for the Hessian sparsity propagator.
// Holds the request, response and chain control structs and the function and opcode names.
// No dependencies.
`timescale 1ns / 1ps

package hsp_pkg;

   localparam int MASK_W  = 64;
   localparam int ID_W    = 10;
   localparam int COL_W   = 6;
   localparam int OP_W    = 4;

   localparam logic [1:0] FN_NODE  = 2'd0;
   localparam logic [1:0] FN_READ  = 2'd1;
   localparam logic [1:0] FN_CLEAR = 2'd2;

   localparam logic [OP_W-1:0] OP_CONST   = 4'd0;
   localparam logic [OP_W-1:0] OP_VAR     = 4'd1;
   localparam logic [OP_W-1:0] OP_SUM     = 4'd2;
   localparam logic [OP_W-1:0] OP_NEGATE  = 4'd3;
   localparam logic [OP_W-1:0] OP_PRODUCT = 4'd4;
   localparam logic [OP_W-1:0] OP_DIVIDE  = 4'd5;
   localparam logic [OP_W-1:0] OP_POWER   = 4'd6;
   localparam logic [OP_W-1:0] OP_EXP     = 4'd7;
   localparam logic [OP_W-1:0] OP_LOG     = 4'd8;
   localparam logic [OP_W-1:0] OP_SQRT    = 4'd9;
   localparam logic [OP_W-1:0] OP_SIN     = 4'd10;
   localparam logic [OP_W-1:0] OP_COS     = 4'd11;

   localparam logic [1:0] TK_NODE  = 2'd0;
   localparam logic [1:0] TK_READ  = 2'd1;
   localparam logic [1:0] TK_CLEAR = 2'd2;
   localparam logic [1:0] TK_NONE  = 2'd3;

   typedef struct packed {
      logic [1:0]       func;
      logic [OP_W-1:0]  node_op;
      logic [ID_W-1:0]  node_id;
      logic [1:0]       child_count;
      logic [ID_W-1:0]  child_a;
      logic [ID_W-1:0]  child_b;
      logic [COL_W-1:0] variable;
      logic             power_nonlinear;
      logic [COL_W-1:0] column;
   } hsp_req_type;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic              is_column;
   } hsp_rsp_type;

   typedef struct packed {
      logic             valid;
      logic [1:0]       kind;
      logic             sq;
      logic [COL_W-1:0] col;
   } hsp_ctl_type;

endpackage

FILE: rtl/hsp_cell.sv
// One column of the lower-triangle pattern, one stage of the systolic chain.
// Depends on hsp_pkg for the chain control struct and token kinds.
`timescale 1ns / 1ps

module hsp_cell import hsp_pkg::*; #(
   parameter int MAX_VARS = 64,
   parameter int CELL_COL = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  hsp_ctl_type         up_ctl,
   input  logic [MAX_VARS-1:0] up_a,
   input  logic [MAX_VARS-1:0] up_b,
   input  logic [MAX_VARS-1:0] up_mask,
   output hsp_ctl_type         dn_ctl,
   output logic [MAX_VARS-1:0] dn_a,
   output logic [MAX_VARS-1:0] dn_b,
   output logic [MAX_VARS-1:0] dn_mask
);

   localparam logic [MAX_VARS-1:0] LOWER = {MAX_VARS{1'b1}} << CELL_COL;

   logic [MAX_VARS-1:0] column_ff, column_in;
   hsp_ctl_type         ctl_ff;
   logic [MAX_VARS-1:0] a_ff, b_ff, mask_ff, mask_in;
   logic [MAX_VARS-1:0] rows;

   always_comb begin
      rows = (({MAX_VARS{up_a[CELL_COL]}} & up_b)
             | ({MAX_VARS{up_b[CELL_COL]}} & (up_a | ({MAX_VARS{up_ctl.sq}} & up_b))))
             & LOWER;
      column_in = column_ff;
      mask_in   = up_mask;
      if (up_ctl.valid) begin
         case (up_ctl.kind)
            TK_NODE:  column_in = column_ff | rows;
            TK_CLEAR: column_in = '0;
            TK_READ: begin
               if (up_ctl.col == COL_W'(CELL_COL)) begin
                  mask_in = column_ff;
               end
            end
            default: column_in = column_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         ctl_ff    <= '0;
      end else begin
         column_ff <= column_in;
         ctl_ff    <= up_ctl;
      end
      a_ff    <= up_a;
      b_ff    <= up_b;
      mask_ff <= mask_in;
   end

   assign dn_ctl  = ctl_ff;
   assign dn_a    = a_ff;
   assign dn_b    = b_ff;
   assign dn_mask = mask_ff;

endmodule

FILE: rtl/hsp_domain.sv
// Node domain store and item sequencer that feeds tokens into the column chain.
// Depends on hsp_pkg for the request struct, chain control struct and codes.
`timescale 1ns / 1ps

module hsp_domain import hsp_pkg::*; #(
   parameter int MAX_VARS  = 64,
   parameter int MAX_NODES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  hsp_req_type         req_data,
   output hsp_ctl_type         inj_ctl,
   output logic [MAX_VARS-1:0] inj_a,
   output logic [MAX_VARS-1:0] inj_b,
   output logic [MAX_VARS-1:0] inj_mask
);

   localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam logic [NODE_AW-1:0] LAST_NODE = NODE_AW'(MAX_NODES - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ISSUE = 3'd1;
   localparam logic [2:0] S_RD2   = 3'd2;
   localparam logic [2:0] S_WR    = 3'd3;
   localparam logic [2:0] S_CLR   = 3'd4;

   logic [2:0]          state_ff, state_in;
   hsp_req_type         req_ff, req_in;
   logic [NODE_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [MAX_VARS-1:0] da_ff, da_in, db_ff, db_in;
   hsp_ctl_type         ctl_ff, ctl_in;
   logic [MAX_VARS-1:0] a_ff, a_in, b_ff, b_in, mask_ff, mask_in;

   logic [MAX_VARS-1:0] mem [MAX_NODES];
   logic [MAX_VARS-1:0] rd0_ff, rd1_ff;
   logic [NODE_AW-1:0]  rd0_addr, rd1_addr, wr_addr;
   logic                wr_en;
   logic [MAX_VARS-1:0] wr_data;

   logic                a_ok, b_ok, id_ok;
   logic [MAX_VARS-1:0] mine_old, mine, var_bit, op_a, op_b;
   logic                op_sq;

   always_comb begin
      a_ok  = (req_ff.child_count != 2'd0) && (32'(req_ff.child_a) < MAX_NODES);
      b_ok  = req_ff.child_count[1] && (32'(req_ff.child_b) < MAX_NODES);
      id_ok = 32'(req_ff.node_id) < MAX_NODES;
      mine_old = id_ok ? rd0_ff : '0;
      var_bit  = MAX_VARS'(1) << req_ff.variable;
      if (req_ff.node_op == OP_VAR) begin
         mine = mine_old | var_bit;
      end else begin
         mine = mine_old | da_ff | db_ff;
      end
      op_a  = '0;
      op_b  = '0;
      op_sq = 1'b0;
      case (req_ff.node_op) inside
         OP_PRODUCT: begin
            op_a = da_ff;
            op_b = db_ff;
         end
         OP_DIVIDE: begin
            if (db_ff != '0) begin
               op_a  = da_ff;
               op_b  = db_ff;
               op_sq = 1'b1;
            end
         end
         OP_POWER: begin
            if (req_ff.power_nonlinear) begin
               op_a = da_ff;
               op_b = da_ff;
            end
         end
         OP_EXP, OP_LOG, OP_SQRT, OP_SIN, OP_COS: begin
            op_a = da_ff;
            op_b = da_ff;
         end
         default: op_sq = 1'b0;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      clr_cnt_in = clr_cnt_ff;
      da_in      = da_ff;
      db_in      = db_ff;
      ctl_in     = '0;
      a_in       = '0;
      b_in       = '0;
      mask_in    = '0;
      rd0_addr   = NODE_AW'(req_ff.child_a);
      rd1_addr   = NODE_AW'(req_ff.child_b);
      wr_en      = 1'b0;
      wr_addr    = NODE_AW'(req_ff.node_id);
      wr_data    = mine;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if (req_ff.func == FN_NODE) begin
               state_in = S_RD2;
            end else begin
               ctl_in.valid = 1'b1;
               ctl_in.col   = req_ff.column;
               unique case (req_ff.func)
                  FN_READ:  ctl_in.kind = TK_READ;
                  FN_CLEAR: ctl_in.kind = TK_CLEAR;
                  default:  ctl_in.kind = TK_NONE;
               endcase
               clr_cnt_in = '0;
               state_in   = (req_ff.func == FN_CLEAR) ? S_CLR : S_IDLE;
            end
         end
         S_RD2: begin
            da_in    = a_ok ? rd0_ff : '0;
            db_in    = b_ok ? rd1_ff : '0;
            rd0_addr = NODE_AW'(req_ff.node_id);
            state_in = S_WR;
         end
         S_WR: begin
            wr_en        = id_ok;
            ctl_in.valid = 1'b1;
            ctl_in.kind  = TK_NODE;
            ctl_in.sq    = op_sq;
            a_in         = op_a;
            b_in         = op_b;
            mask_in      = mine;
            state_in     = S_IDLE;
         end
         S_CLR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_NODE) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd0_ff <= mem[rd0_addr];
      rd1_ff <= mem[rd1_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         clr_cnt_ff <= '0;
         ctl_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         ctl_ff     <= ctl_in;
      end
      req_ff  <= req_in;
      da_ff   <= da_in;
      db_ff   <= db_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      mask_ff <= mask_in;
   end

   assign busy     = (state_ff != S_IDLE);
   assign inj_ctl  = ctl_ff;
   assign inj_a    = a_ff;
   assign inj_b    = b_ff;
   assign inj_mask = mask_ff;

   a_token_spacing: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid |=> !ctl_ff.valid)
      else $error("two tokens entered the chain in consecutive cycles");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("sequencer not busy after taking a beat");

   a_write_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR) |=> (ctl_ff.valid && ctl_ff.kind == TK_NODE))
      else $error("node write without a node token");

endmodule

FILE: rtl/hessian_sparsity_propagator.sv
// Top level: domain sequencer feeding a chain of pattern columns, one per variable.
// Depends on hsp_pkg, hsp_domain and hsp_cell.
//
//   channel   ports                        direction  handshake
//   request   start, busy, req_data        in         taken when start is high and busy low
//   response  rsp_valid, rsp_data          out        one beat per request, one cycle wide
//
// A node request passes the issue, second-read and write states, set by its three domain
// reads through the two read ports of the domain memory; read and unused requests end
// after the issue state. Each token passes the register of every column before its
// response leaves the chain. After reset and after a clear request all MAX_NODES entries
// of the domain memory are swept with busy high.
// Responses cannot be stalled by the receiver.
`timescale 1ns / 1ps

module hessian_sparsity_propagator import hsp_pkg::*; #(
   parameter int MAX_VARS  = 64,
   parameter int MAX_NODES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  hsp_req_type req_data,
   output logic        rsp_valid,
   output hsp_rsp_type rsp_data
);

   hsp_ctl_type         ctl_chain  [MAX_VARS+1];
   logic [MAX_VARS-1:0] a_chain    [MAX_VARS+1];
   logic [MAX_VARS-1:0] b_chain    [MAX_VARS+1];
   logic [MAX_VARS-1:0] mask_chain [MAX_VARS+1];

   hsp_domain #(
      .MAX_VARS  (MAX_VARS),
      .MAX_NODES (MAX_NODES)
   ) u_domain (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .inj_ctl  (ctl_chain[0]),
      .inj_a    (a_chain[0]),
      .inj_b    (b_chain[0]),
      .inj_mask (mask_chain[0])
   );

   for (genvar c = 0; c < MAX_VARS; c++) begin : g_col
      hsp_cell #(
         .MAX_VARS (MAX_VARS),
         .CELL_COL (c)
      ) u_col (
         .clock   (clock),
         .reset   (reset),
         .up_ctl  (ctl_chain[c]),
         .up_a    (a_chain[c]),
         .up_b    (b_chain[c]),
         .up_mask (mask_chain[c]),
         .dn_ctl  (ctl_chain[c+1]),
         .dn_a    (a_chain[c+1]),
         .dn_b    (b_chain[c+1]),
         .dn_mask (mask_chain[c+1])
      );
   end

   always_comb begin
      rsp_valid          = ctl_chain[MAX_VARS].valid;
      rsp_data.mask      = MASK_W'(mask_chain[MAX_VARS]);
      rsp_data.is_column = (ctl_chain[MAX_VARS].kind == TK_READ);
   end

   a_chain_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(ctl_chain[0].valid, MAX_VARS))
      else $error("response beat without a token issued a chain length earlier");

   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      (ctl_chain[0].valid && ctl_chain[0].kind == TK_CLEAR) |-> busy)
      else $error("clear token issued without a memory sweep in progress");

endmodule
